// ===== rtl/cfc_pkg.sv =====
`default_nettype none

package cfc_pkg;

   localparam logic [7:0] FRAME_HEADER = 8'hAA;
   localparam logic [7:0] FRAME_TAIL   = 8'h55;
   localparam logic [7:0] CMD_MOVE     = 8'h01;
   localparam logic [7:0] CMD_RESET    = 8'h04;
   localparam logic [7:0] DEVICE_ID_RESET = 8'h01;

   // byte positions within a frame
   localparam logic [2:0] POS_HEADER   = 3'd0;
   localparam logic [2:0] POS_ID       = 3'd1;
   localparam logic [2:0] POS_COMMAND  = 3'd2;
   localparam logic [2:0] POS_DIR      = 3'd3;
   localparam logic [2:0] POS_STEPS_HI = 3'd4;
   localparam logic [2:0] POS_STEPS_LO = 3'd5;
   localparam logic [2:0] POS_CHECKSUM = 3'd6;
   localparam logic [2:0] POS_TAIL     = 3'd7;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_HEADER   = 3'd1,
      ST_TAIL     = 3'd2,
      ST_ID       = 3'd3,
      ST_CHECKSUM = 3'd4,
      ST_COMMAND  = 3'd5
   } status_type;

   // what the tracker has gathered of the frame so far
   typedef struct packed {
      logic        header_bad;
      logic        id_bad;
      logic        checksum_bad;
      logic [7:0]  command;
      logic [7:0]  direction;
      logic [15:0] steps;
   } frame_info_type;

endpackage

`default_nettype wire

// ===== rtl/cfc_frame_track.sv =====
`default_nettype none

module cfc_frame_track
   import cfc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     rx_byte,
   input  wire logic [7:0]     device_id,
   output logic [2:0]          position,
   output frame_info_type      info
);

   logic [2:0]     pos_ff, pos_in;
   logic [7:0]     xor_ff, xor_in;
   frame_info_type info_ff, info_in;

   // gather one byte of the frame by its position
   always_comb begin
      pos_in  = pos_ff;
      xor_in  = xor_ff;
      info_in = info_ff;
      if (accept) begin
         pos_in = pos_ff + 3'd1;
         unique case (pos_ff)
            POS_HEADER: begin
               info_in.header_bad = (rx_byte != FRAME_HEADER);
               xor_in = 8'h00;
            end
            POS_ID: begin
               info_in.id_bad = (rx_byte != device_id);
               xor_in = rx_byte;
            end
            POS_COMMAND: begin
               info_in.command = rx_byte;
               xor_in = xor_ff ^ rx_byte;
            end
            POS_DIR: begin
               info_in.direction = rx_byte;
               xor_in = xor_ff ^ rx_byte;
            end
            POS_STEPS_HI: begin
               info_in.steps[15:8] = rx_byte;
               xor_in = xor_ff ^ rx_byte;
            end
            POS_STEPS_LO: begin
               info_in.steps[7:0] = rx_byte;
               xor_in = xor_ff ^ rx_byte;
            end
            POS_CHECKSUM: begin
               info_in.checksum_bad = (rx_byte != xor_ff);
            end
            POS_TAIL: begin
               // tail is judged by the result stage
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HEADER;
         xor_ff  <= 8'h00;
         info_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         xor_ff  <= xor_in;
         info_ff <= info_in;
      end
   end

   assign position = pos_ff;
   assign info     = info_ff;

endmodule

`default_nettype wire

// ===== rtl/command_frame_checker.sv =====
// Frame checker for fixed eight-byte command frames, one byte per transfer.
// Throughput: one byte per cycle; bytes 0 to 6 are taken even while a result waits.
// The result is registered and appears in the cycle after the tail byte is accepted.
// The tail byte stalls only while the previous result sits unclaimed in the output register.
// Reset (synchronous, active high): frame position to byte 0, device id to 1, no result.
`default_nettype none

module command_frame_checker
   import cfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_direction,
   output logic [15:0]      rsp_steps,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   logic [7:0]     device_id_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     status_ff, status_in;
   logic [7:0]     command_ff, command_in;
   logic [7:0]     direction_ff, direction_in;
   logic [15:0]    steps_ff, steps_in;
   logic [2:0]     position;
   frame_info_type info;
   logic           req_accept;
   logic           tail_accept;
   logic           fields_kept;

   // register write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         device_id_ff <= csr_data;
      end
   end

   // only the tail byte needs room in the output register
   assign req_ready   = (position != POS_TAIL) || !rsp_valid_ff || rsp_ready;
   assign req_accept  = req_valid && req_ready;
   assign tail_accept = req_accept && (position == POS_TAIL);

   cfc_frame_track u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_rx_byte),
      .device_id (device_id_ff),
      .position  (position),
      .info      (info)
   );

   // judge the frame in check order
   always_comb begin
      priority if (info.header_bad) begin
         status_in = ST_HEADER;
      end else if (req_rx_byte != FRAME_TAIL) begin
         status_in = ST_TAIL;
      end else if (info.id_bad) begin
         status_in = ST_ID;
      end else if (info.checksum_bad) begin
         status_in = ST_CHECKSUM;
      end else if (info.command < CMD_MOVE || info.command > CMD_RESET) begin
         status_in = ST_COMMAND;
      end else begin
         status_in = ST_OK;
      end
      fields_kept  = (status_in == ST_OK) || (status_in == ST_COMMAND);
      command_in   = fields_kept ? info.command   : 8'h00;
      direction_in = fields_kept ? info.direction : 8'h00;
      steps_in     = fields_kept ? info.steps     : 16'h0000;
   end

   // hold the result until transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tail_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_accept) begin
         status_ff    <= status_in;
         command_ff   <= command_in;
         direction_ff <= direction_in;
         steps_ff     <= steps_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_command   = command_ff;
   assign rsp_direction = direction_ff;
   assign rsp_steps     = steps_ff;

`ifndef SYNTH
   // a tail byte always yields a result next cycle
   a_tail_gives_result: assert property (@(posedge clock) disable iff (reset)
      tail_accept |=> rsp_valid)
      else $error("tail byte accepted without a result");

   // a waiting result blocks the tail byte
   a_tail_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && position == POS_TAIL) |-> !req_ready)
      else $error("tail byte taken over a waiting result");

   // framing errors carry zeroed fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_HEADER || rsp_status == ST_TAIL ||
                     rsp_status == ST_ID || rsp_status == ST_CHECKSUM))
      |-> (rsp_command == 8'h00 && rsp_direction == 8'h00 && rsp_steps == 16'h0000))
      else $error("error result carries frame fields");
`endif

endmodule

`default_nettype wire
